// ===== sv/morse_text_keyer_unit_defines.svh =====
// assertion macros for the morse text keyer
`ifndef MORSE_TEXT_KEYER_UNIT_DEFINES_SVH
`define MORSE_TEXT_KEYER_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define MTK_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mtk assertion failed");
// next-cycle implication
`define MTK_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mtk assertion failed");
`else
`define MTK_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define MTK_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== sv/mtk_pkg.sv =====
package mtk_pkg;

    localparam int DurW    = 24;
    localparam int CfgIdxW = 3;
    localparam int StepW   = 4;

    // register indexes
    localparam logic [CfgIdxW-1:0] CFG_DOT        = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_DASH       = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_ELEM_GAP   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_LETTER_GAP = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_WORD_GAP   = 3'd4;

    localparam logic [DurW-1:0] DOT_RESET        = 24'd100;
    localparam logic [DurW-1:0] DASH_RESET       = 24'd300;
    localparam logic [DurW-1:0] ELEM_GAP_RESET   = 24'd100;
    localparam logic [DurW-1:0] LETTER_GAP_RESET = 24'd200;
    localparam logic [DurW-1:0] WORD_GAP_RESET   = 24'd600;

    // program steps
    localparam logic [StepW-1:0] STEP_IDLE          = 4'd0;
    localparam logic [StepW-1:0] STEP_CHECK_FAIL    = 4'd1;
    localparam logic [StepW-1:0] STEP_CHECK_SPACE   = 4'd2;
    localparam logic [StepW-1:0] STEP_END_WORD      = 4'd3;
    localparam logic [StepW-1:0] STEP_CHECK_CODE    = 4'd4;
    localparam logic [StepW-1:0] STEP_ERROR         = 4'd5;
    localparam logic [StepW-1:0] STEP_CHECK_IN_WORD = 4'd6;
    localparam logic [StepW-1:0] STEP_CHECK_EMITTED = 4'd7;
    localparam logic [StepW-1:0] STEP_WORD_GAP      = 4'd8;
    localparam logic [StepW-1:0] STEP_LETTER_GAP    = 4'd9;
    localparam logic [StepW-1:0] STEP_ELEMENT       = 4'd10;
    localparam logic [StepW-1:0] STEP_ELEM_GAP      = 4'd11;

    // jump conditions
    localparam logic [2:0] COND_NEVER       = 3'd0;
    localparam logic [2:0] COND_ALWAYS      = 3'd1;
    localparam logic [2:0] COND_FAILED      = 3'd2;
    localparam logic [2:0] COND_NOT_SPACE   = 3'd3;
    localparam logic [2:0] COND_CODED       = 3'd4;
    localparam logic [2:0] COND_IN_WORD     = 3'd5;
    localparam logic [2:0] COND_NOT_EMITTED = 3'd6;
    localparam logic [2:0] COND_MORE        = 3'd7;

    // duration sources
    localparam logic [2:0] DUR_ZERO       = 3'd0;
    localparam logic [2:0] DUR_ELEMENT    = 3'd1;
    localparam logic [2:0] DUR_ELEM_GAP   = 3'd2;
    localparam logic [2:0] DUR_LETTER_GAP = 3'd3;
    localparam logic [2:0] DUR_WORD_GAP   = 3'd4;

    // flag updates
    localparam logic [1:0] FLAG_NONE          = 2'd0;
    localparam logic [1:0] FLAG_CLEAR_IN_WORD = 2'd1;
    localparam logic [1:0] FLAG_SET_FAILED    = 2'd2;
    localparam logic [1:0] FLAG_SET_WORD      = 2'd3;

    typedef struct packed {
        logic             wait_input;
        logic             emit;
        logic             key;
        logic [2:0]       dur_sel;
        logic             err;
        logic             last_always;
        logic             last_if_final;
        logic             shift;
        logic [1:0]       flag_op;
        logic [2:0]       cond;
        logic             wrap;
        logic [StepW-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic failed;
        logic is_space;
        logic coded;
        logic in_word;
        logic word_emitted;
        logic more;
    } status_t;

    // pattern left aligned, first element in bit 4, 1 is a dash; len 0 means no code
    typedef struct packed {
        logic [2:0] len;
        logic [4:0] pat;
    } morse_t;

    function automatic morse_t code_of(input logic [7:0] c);
        morse_t m;
        m = '0;
        if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
            case (c[4:0])
                5'd1:  m = '{3'd2, 5'b01000};
                5'd2:  m = '{3'd4, 5'b10000};
                5'd3:  m = '{3'd4, 5'b10100};
                5'd4:  m = '{3'd3, 5'b10000};
                5'd5:  m = '{3'd1, 5'b00000};
                5'd6:  m = '{3'd4, 5'b00100};
                5'd7:  m = '{3'd3, 5'b11000};
                5'd8:  m = '{3'd4, 5'b00000};
                5'd9:  m = '{3'd2, 5'b00000};
                5'd10: m = '{3'd4, 5'b01110};
                5'd11: m = '{3'd3, 5'b10100};
                5'd12: m = '{3'd4, 5'b01000};
                5'd13: m = '{3'd2, 5'b11000};
                5'd14: m = '{3'd2, 5'b10000};
                5'd15: m = '{3'd3, 5'b11100};
                5'd16: m = '{3'd4, 5'b01100};
                5'd17: m = '{3'd4, 5'b11010};
                5'd18: m = '{3'd3, 5'b01000};
                5'd19: m = '{3'd3, 5'b00000};
                5'd20: m = '{3'd1, 5'b10000};
                5'd21: m = '{3'd3, 5'b00100};
                5'd22: m = '{3'd4, 5'b00010};
                5'd23: m = '{3'd3, 5'b01100};
                5'd24: m = '{3'd4, 5'b10010};
                5'd25: m = '{3'd4, 5'b10110};
                5'd26: m = '{3'd4, 5'b11000};
                default: m = '0;
            endcase
        end else if (c inside {[8'h30:8'h39]}) begin
            case (c[3:0])
                4'd0: m = '{3'd5, 5'b11111};
                4'd1: m = '{3'd5, 5'b01111};
                4'd2: m = '{3'd5, 5'b00111};
                4'd3: m = '{3'd5, 5'b00011};
                4'd4: m = '{3'd5, 5'b00001};
                4'd5: m = '{3'd5, 5'b00000};
                4'd6: m = '{3'd5, 5'b10000};
                4'd7: m = '{3'd5, 5'b11000};
                4'd8: m = '{3'd5, 5'b11100};
                4'd9: m = '{3'd5, 5'b11110};
                default: m = '0;
            endcase
        end
        return m;
    endfunction

endpackage

// ===== sv/mtk_seq_rom.sv =====
module mtk_seq_rom import mtk_pkg::*; (
    input  logic [StepW-1:0] step,
    output ctrl_word_t       ctrl
);

    always_comb begin
        ctrl = '0;
        case (step)
            STEP_IDLE: begin
                ctrl.wait_input = 1'b1;
                ctrl.cond       = COND_ALWAYS;
                ctrl.target     = STEP_CHECK_FAIL;
            end
            STEP_CHECK_FAIL: begin
                ctrl.cond   = COND_FAILED;
                ctrl.target = STEP_IDLE;
            end
            STEP_CHECK_SPACE: begin
                ctrl.cond   = COND_NOT_SPACE;
                ctrl.target = STEP_CHECK_CODE;
            end
            STEP_END_WORD: begin
                ctrl.flag_op = FLAG_CLEAR_IN_WORD;
                ctrl.cond    = COND_ALWAYS;
                ctrl.target  = STEP_IDLE;
            end
            STEP_CHECK_CODE: begin
                ctrl.cond   = COND_CODED;
                ctrl.target = STEP_CHECK_IN_WORD;
            end
            STEP_ERROR: begin
                ctrl.emit        = 1'b1;
                ctrl.dur_sel     = DUR_ZERO;
                ctrl.err         = 1'b1;
                ctrl.last_always = 1'b1;
                ctrl.flag_op     = FLAG_SET_FAILED;
                ctrl.cond        = COND_ALWAYS;
                ctrl.target      = STEP_IDLE;
            end
            STEP_CHECK_IN_WORD: begin
                ctrl.cond   = COND_IN_WORD;
                ctrl.target = STEP_LETTER_GAP;
            end
            STEP_CHECK_EMITTED: begin
                ctrl.cond   = COND_NOT_EMITTED;
                ctrl.target = STEP_ELEMENT;
            end
            STEP_WORD_GAP: begin
                ctrl.emit    = 1'b1;
                ctrl.dur_sel = DUR_WORD_GAP;
                ctrl.cond    = COND_ALWAYS;
                ctrl.target  = STEP_ELEMENT;
            end
            STEP_LETTER_GAP: begin
                ctrl.emit    = 1'b1;
                ctrl.dur_sel = DUR_LETTER_GAP;
                ctrl.cond    = COND_NEVER;
            end
            STEP_ELEMENT: begin
                ctrl.emit    = 1'b1;
                ctrl.key     = 1'b1;
                ctrl.dur_sel = DUR_ELEMENT;
                ctrl.cond    = COND_NEVER;
            end
            STEP_ELEM_GAP: begin
                ctrl.emit          = 1'b1;
                ctrl.dur_sel       = DUR_ELEM_GAP;
                ctrl.last_if_final = 1'b1;
                ctrl.shift         = 1'b1;
                ctrl.flag_op       = FLAG_SET_WORD;
                ctrl.cond          = COND_MORE;
                ctrl.target        = STEP_ELEMENT;
                ctrl.wrap          = 1'b1;
            end
            default: begin
                ctrl.cond   = COND_ALWAYS;
                ctrl.target = STEP_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/mtk_datapath.sv =====
module mtk_datapath import mtk_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_accept,
    input  logic [7:0]         in_char,
    input  logic               in_phrase_start,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_idx,
    input  logic [DurW-1:0]    cfg_wdata,
    input  ctrl_word_t         ctrl,
    input  logic               fire,
    input  logic               out_ready,
    output status_t            status,
    output logic               out_free,
    output logic               out_valid,
    output logic               out_key,
    output logic [DurW-1:0]    out_dur,
    output logic               out_err,
    output logic               out_last
);

    logic [DurW-1:0] dot_reg, dash_reg, elem_gap_reg, letter_gap_reg, word_gap_reg;
    logic in_word_reg, in_word_next;
    logic emitted_reg, emitted_next;
    logic failed_reg, failed_next;
    logic is_space_reg, coded_reg;
    logic [4:0] pat_reg;
    logic [2:0] count_reg;
    logic final_elem;
    logic [DurW-1:0] dur_sel_val;
    logic out_valid_reg, out_key_reg, out_err_reg, out_last_reg;
    logic [DurW-1:0] out_dur_reg;
    morse_t in_code;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg        <= DOT_RESET;
            dash_reg       <= DASH_RESET;
            elem_gap_reg   <= ELEM_GAP_RESET;
            letter_gap_reg <= LETTER_GAP_RESET;
            word_gap_reg   <= WORD_GAP_RESET;
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_DOT:        dot_reg        <= cfg_wdata;
                CFG_DASH:       dash_reg       <= cfg_wdata;
                CFG_ELEM_GAP:   elem_gap_reg   <= cfg_wdata;
                CFG_LETTER_GAP: letter_gap_reg <= cfg_wdata;
                CFG_WORD_GAP:   word_gap_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // phrase flags
    always_comb begin
        in_word_next = in_word_reg;
        emitted_next = emitted_reg;
        failed_next  = failed_reg;
        if (in_accept && in_phrase_start) begin
            in_word_next = 1'b0;
            emitted_next = 1'b0;
            failed_next  = 1'b0;
        end
        if (fire) begin
            case (ctrl.flag_op)
                FLAG_CLEAR_IN_WORD: in_word_next = 1'b0;
                FLAG_SET_FAILED:    failed_next  = 1'b1;
                FLAG_SET_WORD: begin
                    in_word_next = 1'b1;
                    emitted_next = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_word_reg <= 1'b0;
            emitted_reg <= 1'b0;
            failed_reg  <= 1'b0;
        end else begin
            in_word_reg <= in_word_next;
            emitted_reg <= emitted_next;
            failed_reg  <= failed_next;
        end
    end

    // character latch and element shifter
    assign in_code = code_of(in_char);

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            is_space_reg <= (in_char inside {8'h20, [8'h09:8'h0D]});
            coded_reg    <= (in_code.len != 3'd0);
            pat_reg      <= in_code.pat;
            count_reg    <= in_code.len;
        end else if (fire && ctrl.shift) begin
            pat_reg   <= {pat_reg[3:0], 1'b0};
            count_reg <= count_reg - 3'd1;
        end
    end

    assign final_elem = (count_reg == 3'd1);

    assign status.failed       = failed_reg;
    assign status.is_space     = is_space_reg;
    assign status.coded        = coded_reg;
    assign status.in_word      = in_word_reg;
    assign status.word_emitted = emitted_reg;
    assign status.more         = (count_reg > 3'd1);

    always_comb begin
        case (ctrl.dur_sel)
            DUR_ELEMENT:    dur_sel_val = pat_reg[4] ? dash_reg : dot_reg;
            DUR_ELEM_GAP:   dur_sel_val = elem_gap_reg;
            DUR_LETTER_GAP: dur_sel_val = letter_gap_reg;
            DUR_WORD_GAP:   dur_sel_val = word_gap_reg;
            default:        dur_sel_val = '0;
        endcase
    end

    // output register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && ctrl.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && ctrl.emit) begin
            out_key_reg  <= ctrl.key;
            out_dur_reg  <= dur_sel_val;
            out_err_reg  <= ctrl.err;
            out_last_reg <= ctrl.last_always || (ctrl.last_if_final && final_elem);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_key   = out_key_reg;
    assign out_dur   = out_dur_reg;
    assign out_err   = out_err_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== sv/morse_text_keyer_unit.sv =====
// morse text keyer: turns a stream of ascii characters into timed key segments
//
// s_ channel: one character per transfer, s_tdata[7:0] is the character and
//   s_tuser[0] marks the first character of a phrase (clears word and error state)
// m_ channel: one key segment per transfer; m_tdata[0] key down, m_tdata[24:1]
//   length in ticks, m_tuser[0] error (no code for the character), m_tlast marks
//   the final segment caused by one character
// cfg channel: cfg_index selects dot, dash, element gap, letter gap, word gap
//   (0 to 4, others ignored), cfg_data is the 24-bit tick count; always ready
// sequencing: a small microprogram walks each character, one step per cycle while
//   no step is held, and each emitting step sends one segment. the next character
//   is taken only once the walk for the last one has returned to the idle step
// a stalled m_ side holds the sequencer on its emitting step; one segment waits
//   in the output register meanwhile
// reset: tick registers return to 100/300/100/200/600, phrase state clears,
//   the output register empties and the sequencer waits for a character
`include "morse_text_keyer_unit_defines.svh"

module morse_text_keyer_unit import mtk_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // input characters
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] char_code
    input  logic [0:0]         s_tuser,   // [0] phrase_start
    // key segments
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,   // [0] key_on, [24:1] duration, [31:25] zero
    output logic [0:0]         m_tuser,   // [0] error
    output logic               m_tlast,
    // tick registers
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [DurW-1:0]    cfg_data
);

    logic [StepW-1:0] step_reg, step_next;
    ctrl_word_t       ctrl;
    status_t          status;
    logic             s_accept;
    logic             fire;
    logic             cond_true;
    logic             out_free;
    logic             out_key;
    logic [DurW-1:0]  out_dur;
    logic             out_err;

    // control store
    mtk_seq_rom u_rom (
        .step (step_reg),
        .ctrl (ctrl)
    );

    assign s_tready  = ctrl.wait_input;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // a step fires when its input arrives or its segment has room; others always fire
    always_comb begin
        if (ctrl.wait_input) begin
            fire = s_tvalid;
        end else if (ctrl.emit) begin
            fire = out_free;
        end else begin
            fire = 1'b1;
        end
    end

    always_comb begin
        case (ctrl.cond)
            COND_ALWAYS:      cond_true = 1'b1;
            COND_FAILED:      cond_true = status.failed;
            COND_NOT_SPACE:   cond_true = !status.is_space;
            COND_CODED:       cond_true = status.coded;
            COND_IN_WORD:     cond_true = status.in_word;
            COND_NOT_EMITTED: cond_true = !status.word_emitted;
            COND_MORE:        cond_true = status.more;
            default:          cond_true = 1'b0;
        endcase
    end

    // step counter with conditional jump; wrap returns to idle
    always_comb begin
        step_next = step_reg;
        if (fire) begin
            if (cond_true) begin
                step_next = ctrl.target;
            end else if (ctrl.wrap) begin
                step_next = STEP_IDLE;
            end else begin
                step_next = StepW'(step_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    mtk_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_accept       (s_accept),
        .in_char         (s_tdata),
        .in_phrase_start (s_tuser[0]),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_idx         (cfg_index),
        .cfg_wdata       (cfg_data),
        .ctrl            (ctrl),
        .fire            (fire),
        .out_ready       (m_tready),
        .status          (status),
        .out_free        (out_free),
        .out_valid       (m_tvalid),
        .out_key         (out_key),
        .out_dur         (out_dur),
        .out_err         (out_err),
        .out_last        (m_tlast)
    );

    assign m_tdata    = {7'd0, out_dur, out_key};
    assign m_tuser[0] = out_err;

    // a character transfer always starts the walk at the failed-phrase check
    `MTK_ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_accept, step_reg == STEP_CHECK_FAIL)
    // an emitting step waits while the output register is blocked
    `MTK_ASSERT_NEXT(a_emit_holds, aclk, aresetn, ctrl.emit && m_tvalid && !m_tready, $stable(step_reg))
    // an error segment is the only segment of its character and carries no timing
    `MTK_ASSERT_IMPL(a_error_last, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast && (m_tdata == 32'd0))

endmodule

// ===== verif/tb_morse_text_keyer_unit.sv =====
`timescale 1ns / 1ps

// one key segment as seen on the m_ side
typedef struct packed {
    bit        key_on;
    bit [23:0] duration;
    bit        error;
    bit        last;
} key_segment_t;

// morse keying predictor plus the queue of segments still owed by the block
class keyer_scoreboard;
    bit [23:0] dot_len, dash_len, elem_gap, letter_gap, word_gap;
    bit in_word, word_sent, phrase_failed;
    key_segment_t segments_due[$];
    int mismatches;
    string letter_pat[26];
    string digit_pat[10];

    function new();
        // d is a dot, D is a dash, first element first
        letter_pat = '{"dD", "Dddd", "DdDd", "Ddd", "d", "ddDd", "DDd", "dddd", "dd",
                       "dDDD", "DdD", "dDdd", "DD", "Dd", "DDD", "dDDd", "DDdD", "dDd",
                       "ddd", "D", "ddD", "dddD", "dDD", "DddD", "DdDD", "DDdd"};
        digit_pat = '{"DDDDD", "dDDDD", "ddDDD", "dddDD", "ddddD",
                      "ddddd", "Ddddd", "DDddd", "DDDdd", "DDDDd"};
        dot_len    = mtk_pkg::DOT_RESET;
        dash_len   = mtk_pkg::DASH_RESET;
        elem_gap   = mtk_pkg::ELEM_GAP_RESET;
        letter_gap = mtk_pkg::LETTER_GAP_RESET;
        word_gap   = mtk_pkg::WORD_GAP_RESET;
        in_word = 1'b0;
        word_sent = 1'b0;
        phrase_failed = 1'b0;
        mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, bit [23:0] value);
        case (idx)
            mtk_pkg::CFG_DOT:        dot_len = value;
            mtk_pkg::CFG_DASH:       dash_len = value;
            mtk_pkg::CFG_ELEM_GAP:   elem_gap = value;
            mtk_pkg::CFG_LETTER_GAP: letter_gap = value;
            mtk_pkg::CFG_WORD_GAP:   word_gap = value;
            default: ;
        endcase
    endfunction

    // empty string for characters without a code
    function string pattern_of(bit [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) return letter_pat[c - 8'h41];
        if (c >= 8'h61 && c <= 8'h7A) return letter_pat[c - 8'h61];
        if (c >= 8'h30 && c <= 8'h39) return digit_pat[c - 8'h30];
        return "";
    endfunction

    function bit is_blank(bit [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function void push_segment(bit key, bit [23:0] dur, bit err, bit fin);
        key_segment_t s;
        s.key_on = key;
        s.duration = dur;
        s.error = err;
        s.last = fin;
        segments_due.push_back(s);
    endfunction

    // returns the number of segments owed, or -1 when the character is dropped
    function int note_char(bit [7:0] c, bit start);
        string p;
        int n;
        if (start) begin
            in_word = 1'b0;
            word_sent = 1'b0;
            phrase_failed = 1'b0;
        end
        if (phrase_failed) return -1;
        if (is_blank(c)) begin
            in_word = 1'b0;
            return 0;
        end
        p = pattern_of(c);
        if (p.len() == 0) begin
            phrase_failed = 1'b1;
            push_segment(1'b0, 24'd0, 1'b1, 1'b1);
            return 1;
        end
        n = 0;
        if (in_word) begin
            push_segment(1'b0, letter_gap, 1'b0, 1'b0);
            n++;
        end else if (word_sent) begin
            push_segment(1'b0, word_gap, 1'b0, 1'b0);
            n++;
        end
        // the gap after the final element closes the character
        for (int i = 0; i < p.len(); i++) begin
            push_segment(1'b1, (p[i] == "D") ? dash_len : dot_len, 1'b0, 1'b0);
            push_segment(1'b0, elem_gap, 1'b0, (i == p.len() - 1));
            n += 2;
        end
        in_word = 1'b1;
        word_sent = 1'b1;
        return n;
    endfunction

    function void flag(string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_segment(key_segment_t got);
        key_segment_t want;
        if (segments_due.size() == 0) begin
            flag($sformatf("segment with none owed: key %0b dur %0d err %0b last %0b",
                           got.key_on, got.duration, got.error, got.last));
            return;
        end
        want = segments_due.pop_front();
        if (got.key_on != want.key_on || got.duration != want.duration ||
            got.error != want.error || got.last != want.last)
            flag($sformatf({"segment mismatch: expected key %0b dur %0d err %0b last %0b,",
                            " got key %0b dur %0d err %0b last %0b"},
                           want.key_on, want.duration, want.error, want.last,
                           got.key_on, got.duration, got.error, got.last));
    endfunction
endclass

module tb_morse_text_keyer_unit;
    import mtk_pkg::*;

    // longest stretch without any transfer: covers a long letter behind a stalled m_ side
    // and the settle pause
    localparam int IDLE_LIMIT = 2000;
    // cycles to let a character with no segment (blank or dropped) finish
    localparam int SETTLE_CYCLES = 24;
    // register indexes the block must ignore
    localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;
    localparam bit [DurW-1:0] TICKS_MAX = 24'hFFFFFF;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = 8'h00;   // [7:0] char_code
    logic [0:0]         s_tuser = 1'b0;    // [0] phrase_start
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [31:0]        m_tdata;           // [0] key_on, [24:1] duration, [31:25] zero
    logic [0:0]         m_tuser;           // [0] error
    logic               m_tlast;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [DurW-1:0]    cfg_data = '0;

    keyer_scoreboard sb;
    bit steady;          // no idling on either side while set
    int in_gap;          // wait before the next character, drawn after each transfer

    morse_text_keyer_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int pick_wait();
        return steady ? 0 : int'($urandom_range(0, 7));
    endfunction

    function automatic bit [7:0] coded_char();
        case ($urandom_range(0, 2))
            0: return 8'h41 + 8'($urandom_range(0, 25));
            1: return 8'h61 + 8'($urandom_range(0, 25));
            default: return 8'h30 + 8'($urandom_range(0, 9));
        endcase
    endfunction

    // space or one of tab, lf, vt, ff, cr
    function automatic bit [7:0] blank_char();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? 8'h20 : 8'h09 + 8'(k);
    endfunction

    function automatic bit [7:0] uncoded_char();
        bit [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (sb.pattern_of(c).len() != 0 || sb.is_blank(c));
        return c;
    endfunction

    // one character transfer; valid stays up when the next one follows at once
    task automatic send_char(input bit [7:0] c, input bit start);
        repeat (in_gap) @(posedge aclk);
        s_tdata <= c;
        s_tuser <= start;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        void'(sb.note_char(c, start));
        in_gap = pick_wait();
        if (in_gap != 0) s_tvalid <= 1'b0;
    endtask

    // all five tick registers back to back, framed by writes to unused indexes
    task automatic write_timing(input bit [DurW-1:0] dot, input bit [DurW-1:0] dash,
                                input bit [DurW-1:0] egap, input bit [DurW-1:0] lgap,
                                input bit [DurW-1:0] wgap);
        logic [CfgIdxW-1:0] idx [7];
        bit [DurW-1:0] val [7];
        idx = '{CFG_SPARE_LO, CFG_DOT, CFG_DASH, CFG_ELEM_GAP, CFG_LETTER_GAP,
                CFG_WORD_GAP, CFG_SPARE_HI};
        val = '{24'($urandom), dot, dash, egap, lgap, wgap, 24'($urandom)};
        foreach (idx[i]) begin
            cfg_index <= idx[i];
            cfg_data <= val[i];
            cfg_valid <= 1'b1;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            sb.set_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // stop feeding, wait for every owed segment, then let a silent character finish
    task automatic drain();
        if (in_gap == 0) s_tvalid <= 1'b0;
        while (sb.segments_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // phrases of words with random letters and digits, blank runs between words,
    // some uncoded characters and raw bytes; a failed phrase is soon restarted
    task automatic run_random(input int items);
        int sent;
        int r;
        bit [7:0] c;
        bit start;
        bit fresh;
        sent = 0;
        fresh = 1'b1;
        steady = ($urandom_range(0, 3) == 0);
        while (sent < items) begin
            if ($urandom_range(0, 39) == 0) steady = !steady;
            r = $urandom_range(0, 99);
            if (r < 65) c = coded_char();
            else if (r < 87) c = blank_char();
            else if (r < 92) c = uncoded_char();
            else c = 8'($urandom_range(0, 255));
            start = fresh || ($urandom_range(0, 59) == 0);
            send_char(c, start);
            sent++;
            fresh = (sb.phrase_failed && $urandom_range(0, 2) == 0) ||
                    ($urandom_range(0, 24) == 0);
        end
    endtask

    // result side: random stall per segment, every accepted segment is checked
    initial begin
        int stall;
        key_segment_t seg;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = pick_wait();
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            seg.key_on = m_tdata[0];
            seg.duration = m_tdata[24:1];
            seg.error = m_tuser[0];
            seg.last = m_tlast;
            sb.check_segment(seg);
        end
    end

    // watchdog on cycles with no transfer on any channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        sb = new();
        steady = 1'b0;
        in_gap = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part at reset timing
        send_char(8'h41, 1'b1);   // A opens a phrase, no leading gap
        send_char(8'h7A, 1'b0);   // lower-case z, letter gap
        send_char(8'h20, 1'b0);   // space ends the word
        send_char(8'h09, 1'b0);   // tab folds into the same separator
        send_char(8'h30, 1'b0);   // 0, all dashes, word gap first
        send_char(8'h39, 1'b0);   // 9
        send_char(8'h0A, 1'b0);   // lf, vt, ff, cr
        send_char(8'h0B, 1'b0);
        send_char(8'h0C, 1'b0);
        send_char(8'h0D, 1'b0);
        send_char(8'h5A, 1'b0);   // upper-case Z, dash dash dot dot
        send_char(8'h35, 1'b0);   // 5, all dots
        send_char(8'h40, 1'b0);   // @ has no code, error and the phrase fails
        send_char(8'h45, 1'b0);   // dropped
        send_char(8'h20, 1'b0);   // dropped
        send_char(8'hFF, 1'b1);   // error on the first character of a phrase
        send_char(8'h4B, 1'b0);   // dropped
        send_char(8'h20, 1'b1);   // phrase opening with a blank
        send_char(8'h6D, 1'b0);   // first letter of the phrase, no gap
        send_char(8'h00, 1'b1);   // nul
        send_char(8'h61, 1'b1);   // lower-case a right after a failed phrase
        send_char(8'h80, 1'b0);   // top bit set
        send_char(8'h5B, 1'b1);   // neighbors of the coded ranges
        send_char(8'h60, 1'b1);
        send_char(8'h2F, 1'b1);
        send_char(8'h3A, 1'b1);
        run_random(65);
        drain();

        // shortest dot, longest dash, zero element and letter gaps
        write_timing(24'd1, TICKS_MAX, 24'd0, 24'd0, TICKS_MAX);
        run_random(65);
        drain();

        // everything at full scale
        write_timing(TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX);
        run_random(65);
        drain();

        // everything at its lower bound, zero word gap too
        write_timing(24'd1, 24'd1, 24'd0, 24'd0, 24'd0);
        run_random(65);
        drain();

        // two random settings
        repeat (2) begin
            write_timing(24'($urandom_range(1, 24'hFFFFFF)), 24'($urandom_range(1, 24'hFFFFFF)),
                         24'($urandom), 24'($urandom), 24'($urandom));
            run_random(65);
            drain();
        end

        if (sb.mismatches == 0 && sb.segments_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mtk_pkg.sv
sv/mtk_seq_rom.sv
sv/mtk_datapath.sv
sv/morse_text_keyer_unit.sv
verif/tb_morse_text_keyer_unit.sv
